### sv/brb_pkg.sv
// shared types and codes for the byte ring buffer with reservation
// no dependencies

package brb_pkg;

   localparam int unsigned KIND_W   = 3;
   localparam int unsigned LEN_W    = 10;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned STATUS_W = 3;

   typedef enum logic [KIND_W-1:0] {
      KIND_RESERVE = 3'd0,
      KIND_WRITE   = 3'd1,
      KIND_COMMIT  = 3'd2,
      KIND_READ    = 3'd3,
      KIND_SKIP    = 3'd4,
      KIND_CLOSE   = 3'd5
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_CLOSED   = 3'd1,
      ST_BLOCK    = 3'd2,
      ST_BUSY     = 3'd3,
      ST_MISMATCH = 3'd4,
      ST_BURST    = 3'd5
   } status_type;

endpackage

### sv/brb_store.sv
// byte store of the ring: one write port, one read port, registered read data
// uses brb_pkg for the byte width

module brb_store #(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned AW    = 10
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [brb_pkg::BYTE_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output logic [brb_pkg::BYTE_W-1:0] rd_data
);

   logic [brb_pkg::BYTE_W-1:0] mem [DEPTH];
   logic [brb_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/byte_ring_buffer_with_reservation_core.sv
// top level of the byte ring buffer with reservation: request decode, ring pointers,
// read sequencer and response register; depends on brb_pkg and brb_store
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_kind, req_length, req_data_byte
//   rsp      out        rsp_valid/rsp_stall  rsp_status, rsp_count, rsp_read_byte, rsp_last
//
// every request except a read of n > 0 bytes gives one response; the spare kind codes give none
// a read of n bytes gives n responses; while the response register is free it issues one store
// read per cycle, and bytes leave at one per cycle through the registered store read data
// reset clears pointers, reservation and close state; the store is not cleared
// rsp_stall holds the response register; req_stall is high while a read streams
// or while a held response cannot be replaced

module byte_ring_buffer_with_reservation_core #(
   parameter int unsigned RING_BYTES     = 1024,
   parameter int unsigned MAX_READ_BURST = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [brb_pkg::KIND_W-1:0]   req_kind,
   input  logic [brb_pkg::LEN_W-1:0]    req_length,
   input  logic [brb_pkg::BYTE_W-1:0]   req_data_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [brb_pkg::STATUS_W-1:0] rsp_status,
   output logic [brb_pkg::LEN_W-1:0]    rsp_count,
   output logic [brb_pkg::BYTE_W-1:0]   rsp_read_byte,
   output logic                         rsp_last
);

   localparam int unsigned PW = $clog2(RING_BYTES);
   localparam int unsigned CW = (PW > brb_pkg::LEN_W) ? PW : brb_pkg::LEN_W;
   localparam int unsigned RW = $clog2(MAX_READ_BURST + 1);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_DATA = 2'b10
   } state_type;

   state_type                    state_ff, state_in;
   logic [PW-1:0]                rd_pos_ff, rd_pos_in;
   logic [PW-1:0]                wr_pos_ff, wr_pos_in;
   logic [PW-1:0]                res_pos_ff, res_pos_in;
   logic [brb_pkg::LEN_W-1:0]    res_rem_ff, res_rem_in;
   logic                         res_active_ff, res_active_in;
   logic                         closed_ff, closed_in;
   logic [RW-1:0]                rd_rem_ff, rd_rem_in;
   logic [brb_pkg::LEN_W-1:0]    rd_count_ff, rd_count_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   brb_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [brb_pkg::LEN_W-1:0]    rsp_count_ff, rsp_count_in;
   logic [brb_pkg::BYTE_W-1:0]   rsp_byte_ff, rsp_byte_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         mem_wr_en;
   logic                         mem_rd_en;
   logic [PW-1:0]                mem_rd_addr;
   logic [brb_pkg::BYTE_W-1:0]   mem_rd_data;

   logic                         out_free;
   logic                         req_take;
   logic [PW-1:0]                stored;
   logic [PW-1:0]                space;
   logic [CW-1:0]                stored_ext;
   logic [CW-1:0]                space_ext;
   logic [CW-1:0]                len_ext;
   logic [CW-1:0]                skip_amt;
   logic [PW:0]                  skip_sum;
   logic [PW-1:0]                skip_pos;
   logic [PW:0]                  rd_inc_sum;
   logic [PW-1:0]                rd_inc_pos;
   logic [PW:0]                  res_inc_sum;
   logic [PW-1:0]                res_inc_pos;
   logic [PW:0]                  gap_sum;

   // ring arithmetic
   always_comb begin
      if (wr_pos_ff >= rd_pos_ff) begin
         gap_sum = {1'b0, wr_pos_ff} - {1'b0, rd_pos_ff};
      end else begin
         gap_sum = {1'b0, wr_pos_ff} + (PW+1)'(RING_BYTES) - {1'b0, rd_pos_ff};
      end
      stored     = gap_sum[PW-1:0];
      space      = PW'(RING_BYTES - 1) - stored;
      stored_ext = CW'(stored);
      space_ext  = CW'(space);
      len_ext    = CW'(req_length);
      skip_amt   = (len_ext > stored_ext) ? stored_ext : len_ext;

      skip_sum = {1'b0, rd_pos_ff} + (PW+1)'(skip_amt);
      if (skip_sum >= (PW+1)'(RING_BYTES)) begin
         skip_sum = skip_sum - (PW+1)'(RING_BYTES);
      end
      skip_pos = skip_sum[PW-1:0];

      rd_inc_sum = {1'b0, rd_pos_ff} + (PW+1)'(1);
      if (rd_inc_sum >= (PW+1)'(RING_BYTES)) begin
         rd_inc_sum = rd_inc_sum - (PW+1)'(RING_BYTES);
      end
      rd_inc_pos = rd_inc_sum[PW-1:0];

      res_inc_sum = {1'b0, res_pos_ff} + (PW+1)'(1);
      if (res_inc_sum >= (PW+1)'(RING_BYTES)) begin
         res_inc_sum = res_inc_sum - (PW+1)'(RING_BYTES);
      end
      res_inc_pos = res_inc_sum[PW-1:0];
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) && out_free);
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      state_in      = state_ff;
      rd_pos_in     = rd_pos_ff;
      wr_pos_in     = wr_pos_ff;
      res_pos_in    = res_pos_ff;
      res_rem_in    = res_rem_ff;
      res_active_in = res_active_ff;
      closed_in     = closed_ff;
      rd_rem_in     = rd_rem_ff;
      rd_count_in   = rd_count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      mem_wr_en     = 1'b0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = rd_pos_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = brb_pkg::ST_OK;
               rsp_count_in  = '0;
               rsp_byte_in   = '0;
               rsp_last_in   = 1'b1;
               unique case (brb_pkg::kind_type'(req_kind))
                  brb_pkg::KIND_RESERVE: begin
                     priority if (res_active_ff) begin
                        rsp_status_in = brb_pkg::ST_BUSY;
                     end else if (closed_ff) begin
                        rsp_status_in = brb_pkg::ST_CLOSED;
                     end else if (space_ext < len_ext) begin
                        rsp_status_in = brb_pkg::ST_BLOCK;
                     end else begin
                        res_pos_in    = wr_pos_ff;
                        res_rem_in    = req_length;
                        res_active_in = 1'b1;
                        rsp_count_in  = req_length;
                     end
                  end
                  brb_pkg::KIND_WRITE: begin
                     priority if (closed_ff) begin
                        rsp_status_in = brb_pkg::ST_CLOSED;
                     end else if (!res_active_ff || (res_rem_ff == '0)) begin
                        rsp_status_in = brb_pkg::ST_MISMATCH;
                     end else begin
                        mem_wr_en  = 1'b1;
                        res_pos_in = res_inc_pos;
                        res_rem_in = res_rem_ff - brb_pkg::LEN_W'(1);
                     end
                  end
                  brb_pkg::KIND_COMMIT: begin
                     priority if (closed_ff) begin
                        rsp_status_in = brb_pkg::ST_CLOSED;
                     end else if (!res_active_ff || (res_rem_ff != '0)) begin
                        rsp_status_in = brb_pkg::ST_MISMATCH;
                     end else begin
                        wr_pos_in     = res_pos_ff;
                        res_active_in = 1'b0;
                     end
                  end
                  brb_pkg::KIND_READ: begin
                     priority if (req_length > brb_pkg::LEN_W'(MAX_READ_BURST)) begin
                        rsp_status_in = brb_pkg::ST_BURST;
                     end else if (stored_ext < len_ext) begin
                        rsp_status_in = closed_ff ? brb_pkg::ST_CLOSED : brb_pkg::ST_BLOCK;
                     end else if (req_length == '0) begin
                        rsp_status_in = brb_pkg::ST_OK;
                     end else begin
                        // no response yet, stream the bytes
                        rsp_valid_in = 1'b0;
                        mem_rd_en    = 1'b1;
                        rd_pos_in    = rd_inc_pos;
                        rd_rem_in    = RW'(req_length);
                        rd_count_in  = req_length;
                        state_in     = S_DATA;
                     end
                  end
                  brb_pkg::KIND_SKIP: begin
                     rd_pos_in = skip_pos;
                  end
                  brb_pkg::KIND_CLOSE: begin
                     closed_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b0;
                  end
               endcase
            end
         end
         S_DATA: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = brb_pkg::ST_OK;
               rsp_count_in  = rd_count_ff;
               rsp_byte_in   = mem_rd_data;
               rsp_last_in   = (rd_rem_ff == RW'(1));
               rd_rem_in     = rd_rem_ff - RW'(1);
               if (rd_rem_ff == RW'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  mem_rd_en = 1'b1;
                  rd_pos_in = rd_inc_pos;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rd_pos_ff     <= '0;
         wr_pos_ff     <= '0;
         res_pos_ff    <= '0;
         res_rem_ff    <= '0;
         res_active_ff <= 1'b0;
         closed_ff     <= 1'b0;
         rd_rem_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_pos_ff     <= rd_pos_in;
         wr_pos_ff     <= wr_pos_in;
         res_pos_ff    <= res_pos_in;
         res_rem_ff    <= res_rem_in;
         res_active_ff <= res_active_in;
         closed_ff     <= closed_in;
         rd_rem_ff     <= rd_rem_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_count_ff   <= rd_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
   end

   brb_store #(
      .DEPTH (RING_BYTES),
      .AW    (PW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (res_pos_ff),
      .wr_data (req_data_byte),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_read_byte = rsp_byte_ff;
   assign rsp_last      = rsp_last_ff;

   // no open reservation means nothing pending beyond the committed data
   a_idle_res_empty: assert property (@(posedge clock) disable iff (reset)
      !res_active_ff |-> (res_rem_ff == '0))
      else $error("closed reservation with bytes remaining");

   a_idle_res_pos: assert property (@(posedge clock) disable iff (reset)
      !res_active_ff |-> (res_pos_ff == wr_pos_ff))
      else $error("reservation position drifted from write position");

   a_stream_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DATA) |->
         ((rd_rem_ff != '0) && (rd_rem_ff <= RW'(MAX_READ_BURST))))
      else $error("read stream byte count out of range");

   a_partial_is_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |->
         ((rsp_status_ff == brb_pkg::ST_OK) && (rsp_count_ff != '0)))
      else $error("non-final response outside a read");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for byte_ring_buffer_with_reservation_core: random and directed
// requests, an in-order ring predictor and a per-field response check; depends on brb_pkg

module tb;

   localparam int unsigned RING      = 1024;
   localparam int unsigned RING_AW   = 10;
   localparam int unsigned BURST_MAX = 64;

   // kind codes with no operation behind them
   localparam logic [brb_pkg::KIND_W-1:0] KIND_SPARE_LO = 3'd6;
   localparam logic [brb_pkg::KIND_W-1:0] KIND_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [brb_pkg::KIND_W-1:0] kind;
      logic [brb_pkg::LEN_W-1:0]  length;
      logic [brb_pkg::BYTE_W-1:0] data;
   } request_type;

   typedef struct packed {
      brb_pkg::status_type        status;
      logic [brb_pkg::LEN_W-1:0]  count;
      logic [brb_pkg::BYTE_W-1:0] rbyte;
      logic                       last;
   } response_type;

   logic                         clock;
   logic                         reset         = 1'b1;
   logic                         req_valid     = 1'b0;
   logic                         req_stall;
   logic [brb_pkg::KIND_W-1:0]   req_kind      = '0;
   logic [brb_pkg::LEN_W-1:0]    req_length    = '0;
   logic [brb_pkg::BYTE_W-1:0]   req_data_byte = '0;
   logic                         rsp_valid;
   logic                         rsp_stall     = 1'b0;
   logic [brb_pkg::STATUS_W-1:0] rsp_status;
   logic [brb_pkg::LEN_W-1:0]    rsp_count;
   logic [brb_pkg::BYTE_W-1:0]   rsp_read_byte;
   logic                         rsp_last;

   byte_ring_buffer_with_reservation_core uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_length    (req_length),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_count     (rsp_count),
      .rsp_read_byte (rsp_read_byte),
      .rsp_last      (rsp_last)
   );

   // predicted ring state
   logic [brb_pkg::BYTE_W-1:0] ring_mem [RING];
   int unsigned       rd_pos    = 0;
   int unsigned       wr_pos    = 0;
   int unsigned       rsv_pos   = 0;
   int unsigned       rsv_left  = 0;
   bit                rsv_open  = 1'b0;
   bit                ring_shut = 1'b0;

   request_type  pending [$];
   response_type rsp_owed [$];
   request_type  cur_req;
   request_type  seen_req;
   response_type want;
   logic        req_taken    = 1'b0;
   int unsigned fail_count   = 0;
   int unsigned items_queued = 0;
   bit          no_gaps      = 1'b0;
   bit          hold_cue     = 1'b0;
   bit          hold_used    = 1'b0;
   int unsigned hold_left    = 0;

   function automatic void owe_rsp(brb_pkg::status_type s, int unsigned c,
                                   logic [brb_pkg::BYTE_W-1:0] b, bit l);
      response_type x;
      x.status = s;
      x.count  = c[brb_pkg::LEN_W-1:0];
      x.rbyte  = b;
      x.last   = l;
      rsp_owed.push_back(x);
   endfunction

   function automatic void ring_apply(request_type r);
      int unsigned fill, room, n;
      fill = (wr_pos + RING - rd_pos) % RING;
      room = RING - 1 - fill;
      n    = 32'(r.length);
      case (r.kind)
         brb_pkg::KIND_RESERVE: begin
            if (rsv_open) owe_rsp(brb_pkg::ST_BUSY, 0, '0, 1'b1);
            else if (ring_shut) owe_rsp(brb_pkg::ST_CLOSED, 0, '0, 1'b1);
            else if (room < n) owe_rsp(brb_pkg::ST_BLOCK, 0, '0, 1'b1);
            else begin
               rsv_pos  = wr_pos;
               rsv_left = n;
               rsv_open = 1'b1;
               owe_rsp(brb_pkg::ST_OK, n, '0, 1'b1);
            end
         end
         brb_pkg::KIND_WRITE: begin
            if (ring_shut) owe_rsp(brb_pkg::ST_CLOSED, 0, '0, 1'b1);
            else if (!rsv_open || rsv_left == 0) owe_rsp(brb_pkg::ST_MISMATCH, 0, '0, 1'b1);
            else begin
               ring_mem[rsv_pos[RING_AW-1:0]] = r.data;
               rsv_pos  = (rsv_pos + 1) % RING;
               rsv_left = rsv_left - 1;
               owe_rsp(brb_pkg::ST_OK, 0, '0, 1'b1);
            end
         end
         brb_pkg::KIND_COMMIT: begin
            if (ring_shut) owe_rsp(brb_pkg::ST_CLOSED, 0, '0, 1'b1);
            else if (!rsv_open || rsv_left != 0) owe_rsp(brb_pkg::ST_MISMATCH, 0, '0, 1'b1);
            else begin
               wr_pos   = rsv_pos;
               rsv_open = 1'b0;
               owe_rsp(brb_pkg::ST_OK, 0, '0, 1'b1);
            end
         end
         brb_pkg::KIND_READ: begin
            if (n > BURST_MAX) owe_rsp(brb_pkg::ST_BURST, 0, '0, 1'b1);
            else if (fill < n)
               owe_rsp(ring_shut ? brb_pkg::ST_CLOSED : brb_pkg::ST_BLOCK, 0, '0, 1'b1);
            else if (n == 0) owe_rsp(brb_pkg::ST_OK, 0, '0, 1'b1);
            else begin
               for (int unsigned i = 0; i < n; i++) begin
                  owe_rsp(brb_pkg::ST_OK, n, ring_mem[rd_pos[RING_AW-1:0]], i == n - 1);
                  rd_pos = (rd_pos + 1) % RING;
               end
            end
         end
         brb_pkg::KIND_SKIP: begin
            if (n > fill) n = fill;
            rd_pos = (rd_pos + n) % RING;
            owe_rsp(brb_pkg::ST_OK, 0, '0, 1'b1);
         end
         brb_pkg::KIND_CLOSE: begin
            ring_shut = 1'b1;
            owe_rsp(brb_pkg::ST_OK, 0, '0, 1'b1);
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(string name, logic [31:0] got, logic [31:0] exp_val);
      if (got !== exp_val) begin
         fail_count++;
         $display("%0t ns: rsp_%s mismatch, expected %0d, got %0d", $time, name, exp_val, got);
      end
   endfunction

   task automatic queue_req(logic [brb_pkg::KIND_W-1:0] k, int unsigned len,
                            int unsigned d);
      request_type r;
      r.kind   = k;
      r.length = len[brb_pkg::LEN_W-1:0];
      r.data   = d[brb_pkg::BYTE_W-1:0];
      pending.push_back(r);
      if (k <= brb_pkg::KIND_CLOSE) items_queued++;
   endtask

   task automatic queue_message(int unsigned n);
      queue_req(brb_pkg::KIND_RESERVE, n, $urandom_range(255));
      repeat (n) queue_req(brb_pkg::KIND_WRITE, $urandom_range(1023), $urandom_range(255));
      queue_req(brb_pkg::KIND_COMMIT, $urandom_range(1023), $urandom_range(255));
   endtask

   task automatic settle();
      do begin
         @(posedge clock);
         #1;
      end while (pending.size() != 0 || req_valid || rsp_owed.size() != 0);
   endtask

   function automatic int unsigned ring_fill();
      return (wr_pos + RING - rd_pos) % RING;
   endfunction

   task automatic random_batch();
      int unsigned fill, room, n, roll, variant, seqs;
      bit noisy;
      fill  = ring_fill();
      noisy = 1'b0;
      if (rsv_open) begin
         repeat (rsv_left)
            queue_req(brb_pkg::KIND_WRITE, $urandom_range(1023), $urandom_range(255));
         queue_req(brb_pkg::KIND_COMMIT, $urandom_range(1023), $urandom_range(255));
         fill = (rsv_pos + rsv_left + RING - rd_pos) % RING;
      end
      room = RING - 1 - fill;
      seqs = $urandom_range(2, 6);
      for (int s = 0; s < seqs && !noisy; s++) begin
         roll = $urandom_range(99);
         if (roll < 50) begin
            n = ($urandom_range(19) == 0) ? $urandom_range(64, 200) : $urandom_range(12);
            if (n > room) n = room;
            variant = $urandom_range(9);
            if (variant == 0 && room < RING - 1) begin
               queue_req(brb_pkg::KIND_RESERVE, $urandom_range(room + 1, RING - 1),
                         $urandom_range(255));
            end else begin
               queue_req(brb_pkg::KIND_RESERVE, n, $urandom_range(255));
               if (variant == 1) queue_req(brb_pkg::KIND_COMMIT, $urandom_range(1023), 0);
               repeat (n)
                  queue_req(brb_pkg::KIND_WRITE, $urandom_range(1023), $urandom_range(255));
               if (variant == 2) queue_req(brb_pkg::KIND_WRITE, 0, $urandom_range(255));
               queue_req(brb_pkg::KIND_COMMIT, $urandom_range(1023), $urandom_range(255));
               fill += n;
               room -= n;
            end
         end else if (roll < 78) begin
            if ($urandom_range(9) == 0) n = $urandom_range(1023);
            else n = $urandom_range((fill < BURST_MAX) ? fill : BURST_MAX);
            queue_req(brb_pkg::KIND_READ, n, $urandom_range(255));
            if (n <= BURST_MAX && n <= fill) begin
               fill -= n;
               room += n;
            end
         end else if (roll < 88) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(6);
            queue_req(brb_pkg::KIND_SKIP, n, $urandom_range(255));
            if (n > fill) n = fill;
            fill -= n;
            room += n;
         end else begin
            // noise; never a close, small reservations only
            repeat ($urandom_range(1, 3)) begin
               variant = $urandom_range(6);
               if (variant == 32'(brb_pkg::KIND_CLOSE)) variant = 32'(KIND_SPARE_HI);
               n = (variant == 32'(brb_pkg::KIND_RESERVE)) ? $urandom_range(31)
                                                            : $urandom_range(1023);
               queue_req(variant[brb_pkg::KIND_W-1:0], n, $urandom_range(255));
            end
            noisy = 1'b1;
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // sender
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending.size() != 0 && (no_gaps || $urandom_range(99) >= 22)) begin
            cur_req        = pending.pop_front();
            req_valid     <= 1'b1;
            req_kind      <= cur_req.kind;
            req_length    <= cur_req.length;
            req_data_byte <= cur_req.data;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_cue && !hold_used) begin
         hold_used <= 1'b1;
         hold_left <= 400;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !no_gaps && ($urandom_range(99) < 22);
      end
   end

   // request capture and response check
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            seen_req.kind   = req_kind;
            seen_req.length = req_length;
            seen_req.data   = req_data_byte;
            ring_apply(seen_req);
         end
         if (rsp_valid && !rsp_stall) begin
            if (rsp_owed.size() == 0) begin
               fail_count++;
               $display("%0t ns: unexpected response, expected none, got status %0d count %0d",
                        $time, rsp_status, rsp_count);
            end else begin
               want = rsp_owed.pop_front();
               check_field("status", 32'(rsp_status), 32'(want.status));
               check_field("count", 32'(rsp_count), 32'(want.count));
               check_field("read_byte", 32'(rsp_read_byte), 32'(want.rbyte));
               check_field("last", 32'(rsp_last), 32'(want.last));
            end
         end
      end
   end

   initial begin
      int unsigned rand_goal, fill, n;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_req(brb_pkg::KIND_READ, 0, 0);
      queue_req(brb_pkg::KIND_READ, 1, 'hff);
      queue_req(brb_pkg::KIND_READ, BURST_MAX + 1, 0);
      queue_req(brb_pkg::KIND_READ, 1023, 0);
      queue_req(brb_pkg::KIND_WRITE, 0, 'h5a);
      queue_req(brb_pkg::KIND_COMMIT, 0, 0);
      queue_req(brb_pkg::KIND_RESERVE, 0, 0);
      queue_req(brb_pkg::KIND_RESERVE, 5, 0);
      queue_req(brb_pkg::KIND_COMMIT, 0, 0);
      queue_req(brb_pkg::KIND_RESERVE, 3, 0);
      queue_req(brb_pkg::KIND_COMMIT, 0, 0);
      queue_req(brb_pkg::KIND_WRITE, 1023, 'h00);
      queue_req(brb_pkg::KIND_WRITE, 0, 'hff);
      queue_req(brb_pkg::KIND_WRITE, 0, 'ha5);
      queue_req(brb_pkg::KIND_WRITE, 0, 'h3c);
      queue_req(brb_pkg::KIND_COMMIT, 1023, 'hff);
      queue_req(brb_pkg::KIND_SKIP, 0, 0);
      queue_req(brb_pkg::KIND_READ, 1, 0);
      queue_req(brb_pkg::KIND_RESERVE, 1023, 0);
      queue_req(brb_pkg::KIND_READ, 3, 0);
      queue_req(brb_pkg::KIND_SKIP, 1023, 0);
      queue_req(brb_pkg::KIND_READ, 1, 0);
      queue_req(KIND_SPARE_LO, 1023, 'hff);
      queue_req(KIND_SPARE_HI, 0, 0);
      settle();

      // long receiver hold while a long message streams in
      rand_goal = items_queued + 400;
      hold_cue  = 1'b1;
      queue_message(40);
      queue_req(brb_pkg::KIND_READ, 40, 0);
      queue_req(brb_pkg::KIND_READ, 1, 0);
      settle();

      while (items_queued < rand_goal) begin
         no_gaps = (items_queued >= rand_goal - 200) && (items_queued < rand_goal - 120);
         random_batch();
         settle();
      end
      no_gaps = 1'b0;

      // close, with or without an open reservation
      if ($urandom_range(1)) begin
         queue_req(brb_pkg::KIND_RESERVE, 4, 0);
         queue_req(brb_pkg::KIND_WRITE, 0, $urandom_range(255));
         queue_req(brb_pkg::KIND_WRITE, 0, $urandom_range(255));
      end
      queue_req(brb_pkg::KIND_CLOSE, $urandom_range(1023), $urandom_range(255));
      queue_req(brb_pkg::KIND_WRITE, 0, $urandom_range(255));
      queue_req(brb_pkg::KIND_COMMIT, 0, 0);
      queue_req(brb_pkg::KIND_RESERVE, 1, 0);
      queue_req(brb_pkg::KIND_READ, BURST_MAX + 1, 0);
      queue_req(brb_pkg::KIND_CLOSE, 0, 0);
      settle();

      fill = ring_fill();
      while (fill != 0) begin
         n = $urandom_range(1, (fill < BURST_MAX) ? fill : BURST_MAX);
         queue_req(brb_pkg::KIND_READ, n, 0);
         fill -= n;
      end
      queue_req(brb_pkg::KIND_READ, 1, 0);
      queue_req(brb_pkg::KIND_READ, 0, 0);
      queue_req(brb_pkg::KIND_SKIP, 1023, 0);
      settle();

      repeat (80) @(posedge clock);
      if (fail_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
